FILE: rtl/acb_pkg.sv
// Package for the arc to cubic Bezier block: constants, tables, state type.
package acb_pkg;

    localparam int MaxSegments = 4;
    localparam logic signed [63:0] HalfPiQ28 = 64'sd421657428;
    localparam logic signed [63:0] CordicGain = 64'sd652032874;
    localparam logic signed [63:0] OneQ30 = 64'sd1073741824;

    localparam logic [1:0] KIND_MOVE  = 2'd0;
    localparam logic [1:0] KIND_LINE  = 2'd1;
    localparam logic [1:0] KIND_CUBIC = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE, S_PREP, S_NDIV, S_SC_K, S_KDIV, S_KMUL, S_SC_P0, S_P0,
        S_EMIT0, S_ANG, S_SC_P1, S_P1, S_ARM, S_EMIT
    } t_state;

    function automatic logic signed [63:0] atan_q30(input logic [4:0] i);
        logic signed [63:0] t;
        unique case (i)
            5'd0: t = 64'h3243F6A8;  5'd1: t = 64'h1DAC6705;  5'd2: t = 64'h0FADBAFC;
            5'd3: t = 64'h07F56EA6;  5'd4: t = 64'h03FEAB76;  5'd5: t = 64'h01FFD55B;
            5'd6: t = 64'h00FFFAAA;  5'd7: t = 64'h007FFF55;  5'd8: t = 64'h003FFFEA;
            5'd9: t = 64'h001FFFFD;  5'd10: t = 64'h000FFFFF; 5'd11: t = 64'h0007FFFF;
            5'd12: t = 64'h0003FFFF; 5'd13: t = 64'h0001FFFF; 5'd14: t = 64'h0000FFFF;
            5'd15: t = 64'h00007FFF; 5'd16: t = 64'h00003FFF; 5'd17: t = 64'h00001FFF;
            5'd18: t = 64'h00000FFF; 5'd19: t = 64'h000007FF; 5'd20: t = 64'h000003FF;
            5'd21: t = 64'h000001FF; 5'd22: t = 64'h000000FF; 5'd23: t = 64'h0000007F;
            5'd24: t = 64'h0000003F; 5'd25: t = 64'h0000001F; 5'd26: t = 64'h0000000F;
            5'd27: t = 64'h00000008; 5'd28: t = 64'h00000004; 5'd29: t = 64'h00000002;
            5'd30: t = 64'h00000001; default: t = 64'h0;
        endcase
        return t;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) r = 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648) r = 32'sh80000000;
        else r = v[31:0];
        return r;
    endfunction

endpackage

FILE: rtl/acb_cordic.sv
// Iterative rotation-mode CORDIC with quadrant reduction, one iteration per cycle.
module acb_cordic import acb_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_go,
    input  logic signed [35:0]  i_angle,
    output logic                o_done,
    output logic signed [63:0]  o_cos,
    output logic signed [63:0]  o_sin
);
    // quadrant found by compare/subtract steps (|a| < 2^32 / 421657428 ~ 10 quarters)
    logic [1:0]         r_ph;       // 0 idle, 1 reduce, 2 iterate
    logic signed [63:0] r_x, r_y, r_z, r_r;
    logic [1:0]         r_q;        // quadrant count, only needed mod 4
    logic [4:0]         r_i;
    logic               r_done;
    logic signed [63:0] w_dx, w_dy;

    assign w_dx = r_y >>> r_i;
    assign w_dy = r_x >>> r_i;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= 2'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_ph)
                2'd0: begin
                    if (i_go) begin
                        // r = a + hp/2, target 0 <= r < hp
                        r_r <= 64'(i_angle) + (HalfPiQ28 >>> 1);
                        r_q <= 2'd0;
                        r_ph <= 2'd1;
                    end
                end
                2'd1: begin
                    if (r_r < 0) begin
                        r_r <= r_r + HalfPiQ28;
                        r_q <= r_q - 2'd1;
                    end else if (r_r >= HalfPiQ28) begin
                        r_r <= r_r - HalfPiQ28;
                        r_q <= r_q + 2'd1;
                    end else begin
                        r_z <= (r_r - (HalfPiQ28 >>> 1)) <<< 2;
                        r_x <= CordicGain;
                        r_y <= 64'sd0;
                        r_i <= 5'd0;
                        r_ph <= 2'd2;
                    end
                end
                default: begin
                    if (r_z >= 0) begin
                        r_x <= r_x - w_dx; r_y <= r_y + w_dy; r_z <= r_z - atan_q30(r_i);
                    end else begin
                        r_x <= r_x + w_dx; r_y <= r_y - w_dy; r_z <= r_z + atan_q30(r_i);
                    end
                    r_i <= r_i + 5'd1;
                    if (r_i == 5'd31) begin
                        r_ph <= 2'd0;
                        r_done <= 1'b1;
                    end
                end
            endcase
        end
    end

    always_comb begin
        unique case (r_q)
            2'd0: begin o_cos = r_x;  o_sin = r_y;  end
            2'd1: begin o_cos = -r_y; o_sin = r_x;  end
            2'd2: begin o_cos = -r_x; o_sin = -r_y; end
            default: begin o_cos = r_y; o_sin = -r_x; end
        endcase
    end
    assign o_done = r_done;
endmodule

FILE: rtl/acb_divider.sv
// Restoring unsigned divider, one quotient bit per cycle, 64-bit operands.
module acb_divider import acb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quot
);
    logic        r_busy, r_done;
    logic [5:0]  r_cnt;
    logic [63:0] r_q, r_d;
    logic [64:0] r_rem;
    logic [64:0] w_sh;

    assign w_sh = {r_rem[63:0], r_q[63]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy) begin
                if (i_go) begin
                    r_busy <= 1'b1;
                    r_q <= i_num;
                    r_d <= i_den;
                    r_rem <= 65'd0;
                    r_cnt <= 6'd0;
                end
            end else begin
                if (w_sh >= {1'b0, r_d}) begin
                    r_rem <= w_sh - {1'b0, r_d};
                    r_q <= {r_q[62:0], 1'b1};
                end else begin
                    r_rem <= w_sh;
                    r_q <= {r_q[62:0], 1'b0};
                end
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

FILE: rtl/arc_to_cubic_bezier_top.sv
// Arc to cubic Bezier top: sequencer around a shared CORDIC, divider and multiplier.
// Setup runs a CORDIC for k, one division and a start-point CORDIC; then each segment
// runs a CORDIC for its end point and the control-arm products. Zero radius or sweep:
// start is ignored, no output. One arc at a time; busy high until its last element;
// the receiver cannot stall. Synchronous reset to idle.
module arc_to_cubic_bezier_top import acb_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_center_x,
    input  logic signed [31:0] i_center_y,
    input  logic [30:0]        i_arc_radius,
    input  logic signed [31:0] i_start_angle,
    input  logic signed [31:0] i_sweep_angle,
    input  logic               i_contour_open,
    output logic               o_valid,
    output logic [1:0]         o_elem_kind,
    output logic signed [31:0] o_ctrl1_x,
    output logic signed [31:0] o_ctrl1_y,
    output logic signed [31:0] o_ctrl2_x,
    output logic signed [31:0] o_ctrl2_y,
    output logic signed [31:0] o_end_x,
    output logic signed [31:0] o_end_y,
    output logic               o_last_of_run
);
    t_state r_state, n_state;
    logic signed [63:0] r_cx, r_cy, r_r, r_start, r_mag, r_step, r_ang;
    logic               r_neg, r_open;
    logic [2:0]         r_n, r_i;
    logic [1:0]         r_sub;
    logic signed [63:0] r_kr, r_s, r_c, r_p0x, r_p0y, r_p1x, r_p1y;
    logic signed [63:0] r_co1, r_si1;
    logic signed [63:0] r_a1, r_a2, r_a3, r_a4;
    logic               r_cgo, r_dgo;
    logic signed [35:0] r_cang;
    logic [63:0]        r_dnum, r_dden;
    logic               w_cdone, w_ddone;
    logic signed [63:0] w_cos, w_sin;
    logic [63:0]        w_quot;
    // shared 32x32 multiplier operands (k, radius, kR and trig all fit in 32 signed bits)
    logic signed [31:0] r_ma, r_mb;
    logic signed [63:0] w_prod, w_rnd;
    logic               r_valid, r_last;
    logic [1:0]         r_kind;
    logic signed [31:0] r_o1x, r_o1y, r_o2x, r_o2y, r_oex, r_oey;
    logic signed [63:0] r_lim;
    logic               w_kneg;
    logic [63:0]        w_kabs;

    acb_cordic u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(r_cgo), .i_angle(r_cang),
        .o_done(w_cdone), .o_cos(w_cos), .o_sin(w_sin)
    );
    acb_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(r_dgo), .i_num(r_dnum),
        .i_den(r_dden), .o_done(w_ddone), .o_quot(w_quot)
    );

    assign w_prod = 64'(r_ma) * 64'(r_mb);
    assign w_rnd = (w_prod + 64'sd536870912) >>> 30;
    assign w_kneg = r_s[63];
    assign w_kabs = w_quot;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (start && !(i_arc_radius == 31'd0 || i_sweep_angle == 32'sd0))
                          n_state = S_PREP;
            S_PREP:   n_state = S_NDIV;
            S_NDIV:   if (r_sub == 2'd3) n_state = S_SC_K;
            S_SC_K:   if (w_cdone) n_state = S_KDIV;
            S_KDIV:   if (w_ddone) n_state = S_KMUL;
            S_KMUL:   n_state = S_SC_P0;
            S_SC_P0:  if (w_cdone) n_state = S_P0;
            S_P0:     if (r_sub == 2'd1) n_state = S_EMIT0;
            S_EMIT0:  n_state = S_ANG;
            S_ANG:    n_state = S_SC_P1;
            S_SC_P1:  if (w_cdone) n_state = S_P1;
            S_P1:     if (r_sub == 2'd1) n_state = S_ARM;
            S_ARM:    if (r_sub == 2'd3) n_state = S_EMIT;
            S_EMIT:   n_state = (r_i == r_n) ? S_IDLE : S_ANG;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        busy = (r_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_cgo <= 1'b0;
            r_dgo <= 1'b0;
            r_sub <= 2'd0;
        end else begin
            r_state <= n_state;
            r_valid <= 1'b0;
            r_cgo <= 1'b0;
            r_dgo <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    r_cx <= 64'(i_center_x);
                    r_cy <= 64'(i_center_y);
                    r_r <= {33'd0, i_arc_radius};
                    r_start <= 64'(i_start_angle);
                    r_neg <= i_sweep_angle[31];
                    r_mag <= i_sweep_angle[31] ? -64'(i_sweep_angle) : 64'(i_sweep_angle);
                    r_open <= i_contour_open;
                    r_lim <= HalfPiQ28 * 64'(MaxSegments);
                    r_sub <= 2'd0;
                end
                S_PREP: begin
                    if (r_mag > r_lim) r_mag <= r_lim;
                    r_n <= 3'd0;
                    r_ang <= 64'sd0; // running multiple of half pi
                end
                S_NDIV: begin
                    // n by stepping quarter turns (at most four)
                    r_sub <= r_sub + 2'd1;
                    if (r_ang < r_mag) begin
                        r_ang <= r_ang + HalfPiQ28;
                        r_n <= r_n + 3'd1;
                    end
                    if (r_sub == 2'd3) begin
                        // step = mag / n, n in 1..4: n=3 uses a reciprocal multiply, the rest shifts
                        unique case (r_ang < r_mag ? r_n + 3'd1 : r_n)
                            3'd1: r_step <= r_mag;
                            3'd2: r_step <= r_mag >>> 1;
                            3'd4: r_step <= r_mag >>> 2;
                            default: r_step <= (r_mag * 64'sd1431655766) >>> 32;
                        endcase
                        r_sub <= 2'd0;
                    end
                end
                S_SC_K: begin
                    if (r_sub == 2'd0) begin
                        // fix n=3 estimate and sign
                        if (r_n == 3'd3 && r_step * 3 > r_mag) r_step <= r_step - 1;
                        else if (r_n == 3'd3 && (r_step + 1) * 3 <= r_mag)
                            r_step <= r_step + 1;
                        r_sub <= 2'd1;
                    end else if (r_sub == 2'd1) begin
                        if (r_neg) r_step <= -r_step;
                        r_sub <= 2'd2;
                    end else if (r_sub == 2'd2) begin
                        r_cang <= 36'(r_step >>> 2);
                        r_cgo <= 1'b1;
                        r_sub <= 2'd3;
                    end
                    if (w_cdone) begin
                        r_s <= w_sin;
                        r_c <= (w_cos <= 0) ? OneQ30 : w_cos;
                        r_dnum <= 64'(w_sin[63] ? -w_sin : w_sin) << 32;
                        r_dden <= 64'(((w_cos <= 0) ? OneQ30 : w_cos) * 3);
                        r_dgo <= 1'b1;
                        r_sub <= 2'd0;
                    end
                end
                S_KDIV: begin
                    if (w_ddone) begin
                        r_ma <= 32'(w_kneg ? -$signed(w_kabs) : $signed(w_kabs));
                        r_mb <= r_r[31:0];
                    end
                end
                S_KMUL: begin
                    r_kr <= w_rnd;
                    r_cang <= r_start[35:0];
                    r_cgo <= 1'b1;
                    r_i <= 3'd0;
                end
                S_SC_P0: begin
                    if (w_cdone) begin
                        r_co1 <= w_cos; r_si1 <= w_sin;
                        r_ma <= r_r[31:0]; r_mb <= w_cos[31:0];
                        r_sub <= 2'd0;
                    end
                end
                S_P0: begin
                    r_sub <= r_sub + 2'd1;
                    if (r_sub == 2'd0) begin
                        r_p0x <= r_cx + w_rnd;
                        r_mb <= r_si1[31:0];
                    end else begin
                        r_p0y <= r_cy + w_rnd;
                        r_sub <= 2'd0;
                    end
                end
                S_EMIT0: begin
                    r_valid <= 1'b1;
                    r_kind <= r_open ? KIND_LINE : KIND_MOVE;
                    r_o1x <= '0; r_o1y <= '0; r_o2x <= '0; r_o2y <= '0;
                    r_oex <= sat32(r_p0x);
                    r_oey <= sat32(r_p0y);
                    r_last <= 1'b0;
                    r_c <= r_co1; r_s <= r_si1;
                    r_ang <= r_start;
                end
                S_ANG: begin
                    r_ang <= r_ang + r_step;
                    r_cang <= 36'(r_ang + r_step);
                    r_cgo <= 1'b1;
                    r_i <= r_i + 3'd1;
                end
                S_SC_P1: begin
                    if (w_cdone) begin
                        r_co1 <= w_cos; r_si1 <= w_sin;
                        r_ma <= r_r[31:0]; r_mb <= w_cos[31:0];
                        r_sub <= 2'd0;
                    end
                end
                S_P1: begin
                    r_sub <= r_sub + 2'd1;
                    if (r_sub == 2'd0) begin
                        r_p1x <= r_cx + w_rnd;
                        r_mb <= r_si1[31:0];
                    end else begin
                        r_p1y <= r_cy + w_rnd;
                        r_ma <= r_kr[31:0]; r_mb <= r_s[31:0];
                        r_sub <= 2'd0;
                    end
                end
                S_ARM: begin
                    r_sub <= r_sub + 2'd1;
                    unique case (r_sub)
                        2'd0: begin r_a1 <= w_rnd; r_mb <= r_c[31:0];   end
                        2'd1: begin r_a2 <= w_rnd; r_mb <= r_si1[31:0]; end
                        2'd2: begin r_a3 <= w_rnd; r_mb <= r_co1[31:0]; end
                        default: begin r_a4 <= w_rnd; r_sub <= 2'd0; end
                    endcase
                end
                S_EMIT: begin
                    r_valid <= 1'b1;
                    r_kind <= KIND_CUBIC;
                    r_o1x <= sat32(r_p0x - r_a1);
                    r_o1y <= sat32(r_p0y + r_a2);
                    r_o2x <= sat32(r_p1x + r_a3);
                    r_o2y <= sat32(r_p1y - r_a4);
                    r_oex <= sat32(r_p1x);
                    r_oey <= sat32(r_p1y);
                    r_last <= (r_i == r_n);
                    r_p0x <= r_p1x; r_p0y <= r_p1y;
                    r_c <= r_co1; r_s <= r_si1;
                end
                default: ;
            endcase
        end
    end

    assign o_valid = r_valid;
    assign o_elem_kind = r_kind;
    assign o_ctrl1_x = r_o1x;
    assign o_ctrl1_y = r_o1y;
    assign o_ctrl2_x = r_o2x;
    assign o_ctrl2_y = r_o2y;
    assign o_end_x = r_oex;
    assign o_end_y = r_oey;
    assign o_last_of_run = r_last;
endmodule
